### rtl/rcts_pkg.sv
// Package for the RC camera trigger sequencer.
// Register indexes, reset values, hold times, field widths and the sequencer state type.
// No dependencies.
package rcts_pkg;

  localparam int PWM_W   = 12;
  localparam int TIME_W  = 32;
  localparam int STEP_W  = 8;
  localparam int ANGLE_W = 8;
  localparam int CMD_W   = 2;

  // angle divider: dividend is (pulse - min) * 180, at most 4095 * 180
  localparam int NUM_W = 20;
  localparam int DEN_W = PWM_W;
  localparam int CNT_W = $clog2(NUM_W);

  localparam int IN_W  = 80;
  localparam int OUT_W = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_UP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_DOWN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_START = 3'd6;

  localparam logic [PWM_W-1:0]  RST_SWITCH_THR  = 12'd1500;
  localparam logic [PWM_W-1:0]  RST_WHEEL_UP    = 12'd1700;
  localparam logic [PWM_W-1:0]  RST_WHEEL_DOWN  = 12'd1300;
  localparam logic [STEP_W-1:0] RST_SERVO_STEP  = 8'd5;
  localparam logic [PWM_W-1:0]  RST_SERVO_MIN   = 12'd1000;
  localparam logic [PWM_W-1:0]  RST_SERVO_MAX   = 12'd2000;
  localparam logic [PWM_W-1:0]  RST_SERVO_START = 12'd1500;

  localparam logic [TIME_W-1:0] PHOTO_HOLD_MS = 32'd500;
  localparam logic [TIME_W-1:0] MOVIE_HOLD_MS = 32'd1500;
  localparam logic [TIME_W-1:0] POWER_HOLD_MS = 32'd1500;
  localparam logic [7:0]        FULL_ANGLE    = 8'd180;

  localparam logic [CMD_W-1:0] REC_NEUTRAL = 2'd0;
  localparam logic [CMD_W-1:0] REC_PHOTO   = 2'd1;
  localparam logic [CMD_W-1:0] REC_MOVIE   = 2'd2;
  localparam logic [CMD_W-1:0] ZOOM_STOP   = 2'd0;
  localparam logic [CMD_W-1:0] ZOOM_IN     = 2'd1;
  localparam logic [CMD_W-1:0] ZOOM_OUT    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

### rtl/rcts_divider.sv
// Iterative restoring divider for the camera angle, one quotient bit per cycle.
// Uses rcts_pkg for widths and the control/status structs.
module rcts_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  rcts_pkg::div_ctrl_t          ctrl,
  input  logic [rcts_pkg::NUM_W-1:0]   dividend,
  input  logic [rcts_pkg::DEN_W-1:0]   divisor,
  output rcts_pkg::div_stat_t          stat,
  output logic [rcts_pkg::NUM_W-1:0]   quotient
);

  logic [rcts_pkg::DEN_W-1:0] rem;
  logic [rcts_pkg::DEN_W-1:0] den;
  logic [rcts_pkg::CNT_W-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [rcts_pkg::DEN_W:0]   shifted;
  logic [rcts_pkg::DEN_W+1:0] diff;
  logic                       last;

  assign shifted = {rem, quotient[rcts_pkg::NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign last    = (cnt == rcts_pkg::CNT_W'(rcts_pkg::NUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quotient <= dividend;
      rem      <= '0;
      den      <= divisor;
    end else if (busy) begin
      if (!diff[rcts_pkg::DEN_W+1]) begin
        rem      <= diff[rcts_pkg::DEN_W-1:0];
        quotient <= {quotient[rcts_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[rcts_pkg::DEN_W-1:0];
        quotient <= {quotient[rcts_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  assign stat.done = done;

endmodule

### rtl/rc_camera_trigger_sequencer.sv
// RC camera trigger sequencer: top level with frame decode, timers, servo clamp and sequencer.
// Depends on rcts_pkg and rcts_divider.
//
// Usage:
//   Slave stream takes one control frame per transfer (timestamp plus four RC pulse
//   widths). Master stream gives one command word per frame. The user must write
//   registers through cfg_we/cfg_index/cfg_data only while the block is idle;
//   the block itself does not enforce this. Flags, timestamps and the servo
//   pulse are registered when the frame is accepted. The camera angle is then
//   multiplied in ST_MUL and goes through the restoring divider, one quotient
//   bit per cycle. s_tready stays low from acceptance until the result is
//   loaded into the output register, so no new frame is taken meanwhile.
//   The output register holds a finished result; a new frame is accepted while
//   it waits, and its result waits in the last sequencer state until the
//   receiver takes the old one. Stalling m_tready holds m_tdata stable.
//   Reset (rst, synchronous) restores the configuration registers to their
//   defaults, clears the flags and stamps and loads the servo pulse with 1500.
//   servo_start has no effect after that, since reset reloads its default as well.
module rc_camera_trigger_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // now_ms[31:0], mode_pwm[43:32], wheel_pwm[55:44], photo_pwm[67:56], movie_pwm[79:68]
  input  logic [rcts_pkg::IN_W-1:0]         s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // record_cmd[1:0], zoom_cmd[3:2], focus_cmd[4], power_cmd[5], servo_pulse[17:6],
  // camera_angle[25:18], zero[31:26]
  output logic [rcts_pkg::OUT_W-1:0]        m_tdata,
  input  logic                              cfg_we,
  input  logic [rcts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcts_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW = rcts_pkg::PWM_W;
  localparam int TW = rcts_pkg::TIME_W;

  // configuration
  logic [PW-1:0]              switch_threshold;
  logic [PW-1:0]              wheel_up_threshold;
  logic [PW-1:0]              wheel_down_threshold;
  logic [rcts_pkg::STEP_W-1:0] servo_step;
  logic [PW-1:0]              servo_min;
  logic [PW-1:0]              servo_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_threshold     <= rcts_pkg::RST_SWITCH_THR;
      wheel_up_threshold   <= rcts_pkg::RST_WHEEL_UP;
      wheel_down_threshold <= rcts_pkg::RST_WHEEL_DOWN;
      servo_step           <= rcts_pkg::RST_SERVO_STEP;
      servo_min            <= rcts_pkg::RST_SERVO_MIN;
      servo_max            <= rcts_pkg::RST_SERVO_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        rcts_pkg::CFG_SWITCH_THR:  switch_threshold     <= cfg_data;
        rcts_pkg::CFG_WHEEL_UP:    wheel_up_threshold   <= cfg_data;
        rcts_pkg::CFG_WHEEL_DOWN:  wheel_down_threshold <= cfg_data;
        rcts_pkg::CFG_SERVO_STEP:  servo_step           <= cfg_data[rcts_pkg::STEP_W-1:0];
        rcts_pkg::CFG_SERVO_MIN:   servo_min            <= cfg_data;
        rcts_pkg::CFG_SERVO_MAX:   servo_max            <= cfg_data;
        // servo start only matters at reset, which reloads its default
        rcts_pkg::CFG_SERVO_START: ;
        default: ;
      endcase
    end
  end

  // frame fields
  logic [TW-1:0] now_ms;
  logic [PW-1:0] mode_pwm, wheel_pwm, photo_pwm, movie_pwm;

  assign now_ms    = s_tdata[31:0];
  assign mode_pwm  = s_tdata[43:32];
  assign wheel_pwm = s_tdata[55:44];
  assign photo_pwm = s_tdata[67:56];
  assign movie_pwm = s_tdata[79:68];

  logic mode_on, wheel_up, wheel_down, photo_on, movie_on;

  assign mode_on    = mode_pwm > switch_threshold;
  assign wheel_up   = wheel_pwm > wheel_up_threshold;
  assign wheel_down = wheel_pwm < wheel_down_threshold;
  assign photo_on   = photo_pwm > switch_threshold;
  assign movie_on   = movie_pwm > switch_threshold;

  // state
  logic          started, powered, power_level, focusing, photo_active, movie_active;
  logic [TW-1:0] power_stamp, photo_stamp, movie_stamp;
  logic [PW-1:0] servo_position;

  logic          started_next, powered_next, power_level_next;
  logic          focusing_next, photo_active_next, movie_active_next;
  logic [TW-1:0] power_stamp_next, photo_stamp_next, movie_stamp_next;
  logic [PW-1:0] servo_position_next;

  logic [TW-1:0] photo_age, movie_age, power_age;

  assign photo_age = now_ms - photo_stamp;
  assign movie_age = now_ms - movie_stamp;
  assign power_age = now_ms - power_stamp;

  always_comb begin
    focusing_next     = focusing;
    photo_active_next = photo_active;
    photo_stamp_next  = photo_stamp;
    if (photo_on && !focusing && !photo_active) begin
      focusing_next = 1'b1;
    end else if (photo_on) begin
      focusing_next = focusing;
    end else if (focusing) begin
      photo_active_next = 1'b1;
      focusing_next     = 1'b0;
      photo_stamp_next  = now_ms;
    end else if (photo_age > rcts_pkg::PHOTO_HOLD_MS) begin
      photo_active_next = 1'b0;
    end

    movie_active_next = movie_active;
    movie_stamp_next  = movie_stamp;
    if (movie_on && !movie_active) begin
      movie_active_next = 1'b1;
      movie_stamp_next  = now_ms;
    end else if (movie_age > rcts_pkg::MOVIE_HOLD_MS) begin
      movie_active_next = 1'b0;
    end

    started_next     = started;
    powered_next     = powered;
    power_level_next = power_level;
    power_stamp_next = power_stamp;
    if (!started) begin
      power_stamp_next = now_ms;
      started_next     = 1'b1;
      power_level_next = 1'b1;
    end else if (!powered) begin
      // level stays high in the frame where the hold runs out
      if (power_age < rcts_pkg::POWER_HOLD_MS) begin
        power_level_next = 1'b1;
      end else begin
        powered_next = 1'b1;
      end
    end else begin
      power_level_next = 1'b0;
    end
  end

  // servo step and clamp; min is checked first so it wins on an inverted range
  logic signed [PW+1:0] pos;
  always_comb begin
    pos = $signed({2'b00, servo_position});
    if (!mode_on && wheel_up) begin
      pos = pos + $signed({{(PW+2-rcts_pkg::STEP_W){1'b0}}, servo_step});
    end else if (!mode_on && wheel_down) begin
      pos = pos - $signed({{(PW+2-rcts_pkg::STEP_W){1'b0}}, servo_step});
    end
    if (pos < $signed({2'b00, servo_min})) begin
      servo_position_next = servo_min;
    end else if (pos > $signed({2'b00, servo_max})) begin
      servo_position_next = servo_max;
    end else begin
      servo_position_next = pos[PW-1:0];
    end
  end

  // frame results held until the angle is ready
  logic [rcts_pkg::CMD_W-1:0] record_cmd, zoom_cmd;
  logic                       focus_cmd;
  logic [rcts_pkg::CMD_W-1:0] record_next, zoom_next;
  logic                       focus_next;

  always_comb begin
    zoom_next = rcts_pkg::ZOOM_STOP;
    if (mode_on && wheel_up) begin
      zoom_next = rcts_pkg::ZOOM_IN;
    end else if (mode_on && wheel_down) begin
      zoom_next = rcts_pkg::ZOOM_OUT;
    end
    focus_next = focusing_next && !photo_active_next;
    if (photo_active_next) begin
      record_next = rcts_pkg::REC_PHOTO;
    end else if (movie_active_next) begin
      record_next = rcts_pkg::REC_MOVIE;
    end else begin
      record_next = rcts_pkg::REC_NEUTRAL;
    end
  end

  // sequencer
  rcts_pkg::st_t       st, st_next;
  rcts_pkg::div_ctrl_t div_ctrl;
  rcts_pkg::div_stat_t div_stat;
  logic                in_fire;
  logic                load_out;
  logic                angle_ok;
  logic                angle_ok_next;
  logic [rcts_pkg::NUM_W-1:0] dividend;
  logic [rcts_pkg::NUM_W-1:0] quotient;
  logic [PW-1:0]              span;
  logic [PW-1:0]              offset;
  logic [rcts_pkg::ANGLE_W-1:0] angle;

  assign in_fire = s_tvalid && s_tready;

  always_comb begin
    st_next = st;
    case (st)
      rcts_pkg::ST_IDLE: if (s_tvalid) st_next = rcts_pkg::ST_MUL;
      rcts_pkg::ST_MUL:  st_next = rcts_pkg::ST_DIV;
      rcts_pkg::ST_DIV:  if (div_stat.done) st_next = rcts_pkg::ST_DONE;
      rcts_pkg::ST_DONE: if (!m_tvalid || m_tready) st_next = rcts_pkg::ST_IDLE;
      default:           st_next = rcts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    div_ctrl.start = 1'b0;
    load_out       = 1'b0;
    case (st)
      rcts_pkg::ST_IDLE: s_tready       = 1'b1;
      rcts_pkg::ST_MUL:  div_ctrl.start = 1'b1;
      rcts_pkg::ST_DIV:  ;
      rcts_pkg::ST_DONE: load_out       = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= rcts_pkg::ST_IDLE;
      started        <= 1'b0;
      powered        <= 1'b0;
      power_level    <= 1'b0;
      focusing       <= 1'b0;
      photo_active   <= 1'b0;
      movie_active   <= 1'b0;
      power_stamp    <= '0;
      photo_stamp    <= '0;
      movie_stamp    <= '0;
      servo_position <= rcts_pkg::RST_SERVO_START;
    end else begin
      st <= st_next;
      if (in_fire) begin
        started        <= started_next;
        powered        <= powered_next;
        power_level    <= power_level_next;
        focusing       <= focusing_next;
        photo_active   <= photo_active_next;
        movie_active   <= movie_active_next;
        power_stamp    <= power_stamp_next;
        photo_stamp    <= photo_stamp_next;
        movie_stamp    <= movie_stamp_next;
        servo_position <= servo_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      record_cmd <= record_next;
      zoom_cmd   <= zoom_next;
      focus_cmd  <= focus_next;
    end
    if (div_ctrl.start) begin
      angle_ok <= angle_ok_next;
    end
  end

  // angle = (pulse - min) * 180 / (max - min); the divider latches the product
  assign angle_ok_next = (servo_max > servo_min) && (servo_position >= servo_min);
  assign span          = angle_ok_next ? (servo_max - servo_min) : PW'(1);
  assign offset        = angle_ok_next ? (servo_position - servo_min) : '0;
  assign dividend      = rcts_pkg::NUM_W'(offset) * rcts_pkg::NUM_W'(rcts_pkg::FULL_ANGLE);

  rcts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (dividend),
    .divisor  (span),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_comb begin
    if (!angle_ok) begin
      angle = '0;
    end else if (quotient > rcts_pkg::NUM_W'(rcts_pkg::FULL_ANGLE)) begin
      angle = rcts_pkg::FULL_ANGLE;
    end else begin
      angle = quotient[rcts_pkg::ANGLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'b000000, angle, servo_position, power_level, focus_cmd, zoom_cmd,
                  record_cmd};
    end
  end

endmodule

### rtl/rcts_checker.sv
// Port-level checker for the RC camera trigger sequencer, bound to the top level.
// Depends only on the top level's ports.
module rcts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // one frame at a time: no second transfer right after the first
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted again right after a transfer");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[25:18] <= 8'd180)
    else $error("camera angle above 180");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[3:2] != 2'd3) && (m_tdata[31:26] == 6'd0))
    else $error("bad record or zoom code or nonzero pad");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rc_camera_trigger_sequencer rcts_checker u_rcts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
